// File: sv/bprr_pkg.sv
// Shared types, codes and sizing for the buffer pool tag keeper.
// No dependencies; imported by bprr_scan, buffer_pool_round_robin_pinning and the testbench.
`timescale 1ns / 1ps

package bprr_pkg;

  localparam int POOL_SIZE = 8;
  localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_PIN    = 2'd1;
  localparam logic [1:0] CMD_UNPIN  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_ID       = 2'd1;
  localparam logic [1:0] ST_FULL         = 2'd2;
  localparam logic [1:0] ST_NOT_RESIDENT = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] blk_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic       fetch_needed;
    logic       evicted;
    logic [6:0] evicted_id;
  } rsp_t;

  // one word of the slot table
  typedef struct packed {
    logic       valid;
    logic       pinned;
    logic [6:0] tag;
  } entry_t;

  typedef struct packed {
    logic clear;  // new request: drop all candidates
    logic valid;  // read data carries a slot entry this cycle
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              empty;
    logic [SLOT_W-1:0] empty_idx;
    logic              vic_found;
    logic [SLOT_W-1:0] vic_idx;
    logic [6:0]        vic_tag;
  } scan_res_t;

  function automatic logic [2:0] to_slot3(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+2:0] w;
    w = {3'b000, idx};
    return w[2:0];
  endfunction

endpackage

// File: sv/bprr_scan.sv
// Candidate tracker for the slot table scan: lookup hit, first empty slot,
// round-robin victim. Entries arrive one per cycle. Depends on bprr_pkg.
`timescale 1ns / 1ps

module bprr_scan import bprr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [SLOT_W-1:0] idx,
  input  entry_t            entry,
  input  logic [6:0]        id,
  input  logic [SLOT_W-1:0] start,
  output scan_res_t         res
);

  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              empty;
  logic [SLOT_W-1:0] empty_idx;
  // hi: first unpinned at or after start; lo: first unpinned overall (wrap)
  logic              vic_hi;
  logic [SLOT_W-1:0] vic_hi_idx;
  logic [6:0]        vic_hi_tag;
  logic              vic_lo;
  logic [SLOT_W-1:0] vic_lo_idx;
  logic [6:0]        vic_lo_tag;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hit    <= 1'b0;
      empty  <= 1'b0;
      vic_hi <= 1'b0;
      vic_lo <= 1'b0;
    end else if (ctl.valid) begin
      if (!hit && entry.valid && entry.tag == id) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end
      if (!empty && !entry.valid) begin
        empty     <= 1'b1;
        empty_idx <= idx;
      end
      if (!entry.pinned) begin
        if (!vic_hi && idx >= start) begin
          vic_hi     <= 1'b1;
          vic_hi_idx <= idx;
          vic_hi_tag <= entry.tag;
        end
        if (!vic_lo) begin
          vic_lo     <= 1'b1;
          vic_lo_idx <= idx;
          vic_lo_tag <= entry.tag;
        end
      end
    end
  end

  always_comb begin
    res.hit       = hit;
    res.hit_idx   = hit_idx;
    res.empty     = empty;
    res.empty_idx = empty_idx;
    res.vic_found = vic_hi || vic_lo;
    res.vic_idx   = vic_hi ? vic_hi_idx : vic_lo_idx;
    res.vic_tag   = vic_hi ? vic_hi_tag : vic_lo_tag;
  end

endmodule

// File: sv/buffer_pool_round_robin_pinning.sv
// Top level of the buffer pool tag keeper: slot table memory, sequencer,
// request decision and response register. Depends on bprr_pkg, bprr_scan.
`timescale 1ns / 1ps

// Keeps id, valid and pin marks of POOL_SIZE buffer slots in a single-port
// synchronous table and answers access, pin and unpin requests with the slot
// used, whether a fetch is due and which block (if any) was evicted. After
// reset a clearing pass writes every slot empty; req_stall is high meanwhile.
// Each request then walks the table one entry per cycle through its registered
// read port, after which a decide state decides and writes back and a done
// state loads the response register; done waits while an earlier response is
// still held by rsp_stall. The next request is accepted back in idle. One
// request is in flight at a time; a finished response may wait in its
// register while the next request runs.
module buffer_pool_round_robin_pinning import bprr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [SLOT_W-1:0] last_victim;
  logic [SLOT_W-1:0] start;
  req_t              cur;
  rsp_t              res;

  entry_t            mem [POOL_SIZE];
  entry_t            rd_data;
  logic              rd_vld;
  logic [SLOT_W-1:0] rd_idx;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  scan_ctl_t         sctl;
  scan_res_t         sres;

  logic              dec_we;
  logic [SLOT_W-1:0] dec_idx;
  entry_t            dec_entry;
  logic              dec_lv_we;
  rsp_t              dec_rsp;

  logic accept;
  logic cnt_lt;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cnt_lt    = (cnt < CNT_W'(POOL_SIZE));
  assign start     = (last_victim == SLOT_W'(POOL_SIZE - 1)) ? '0
                                                             : last_victim + SLOT_W'(1);

  // slot table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == S_SCAN && cnt_lt) begin
      rd_data <= mem[cnt[SLOT_W-1:0]];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[SLOT_W-1:0];
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_DECIDE) begin
      mem_we    = dec_we;
      mem_waddr = dec_idx;
      mem_wdata = dec_entry;
    end
  end

  assign sctl.clear = accept;
  assign sctl.valid = rd_vld;

  bprr_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .ctl   (sctl),
    .idx   (rd_idx),
    .entry (rd_data),
    .id    (cur.blk_id),
    .start (start),
    .res   (sres)
  );

  always_comb begin
    dec_we     = 1'b0;
    dec_idx    = '0;
    dec_entry  = '0;
    dec_lv_we  = 1'b0;
    dec_rsp    = '0;
    dec_rsp.status = ST_OK;
    priority if (cur.blk_id == 7'd0 || cur.command == CMD_NONE) begin
      dec_rsp.status = ST_BAD_ID;
    end else if (cur.command == CMD_UNPIN) begin
      if (sres.hit) begin
        dec_we       = 1'b1;
        dec_idx      = sres.hit_idx;
        dec_entry    = '{valid: 1'b1, pinned: 1'b0, tag: cur.blk_id};
        dec_rsp.slot = to_slot3(sres.hit_idx);
      end else begin
        dec_rsp.status = ST_NOT_RESIDENT;
      end
    end else if (sres.hit) begin
      dec_rsp.slot = to_slot3(sres.hit_idx);
      if (cur.command == CMD_PIN) begin
        dec_we    = 1'b1;
        dec_idx   = sres.hit_idx;
        dec_entry = '{valid: 1'b1, pinned: 1'b1, tag: cur.blk_id};
      end
    end else if (sres.empty || sres.vic_found) begin
      dec_we    = 1'b1;
      dec_idx   = sres.empty ? sres.empty_idx : sres.vic_idx;
      dec_entry = '{valid: 1'b1, pinned: (cur.command == CMD_PIN), tag: cur.blk_id};
      dec_rsp.slot         = to_slot3(dec_idx);
      dec_rsp.fetch_needed = 1'b1;
      if (!sres.empty) begin
        dec_lv_we          = 1'b1;
        dec_rsp.evicted    = 1'b1;
        dec_rsp.evicted_id = sres.vic_tag;
      end
    end else begin
      dec_rsp.status = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      last_victim <= SLOT_W'(POOL_SIZE - 1);
      rd_vld      <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN) && cnt_lt;
      rd_idx <= cnt[SLOT_W-1:0];
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(POOL_SIZE - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            cur   <= req;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_lt) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            // last entry is taken by the tracker on this edge
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          res <= dec_rsp;
          if (dec_lv_we) begin
            last_victim <= dec_idx;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !mem_we)
    else $error("slot table written during scan");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside completion");

  a_evict_fetch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> rsp.fetch_needed && rsp.status == ST_OK)
    else $error("eviction without fetch");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |->
      rsp.slot == 3'd0 && !rsp.fetch_needed && !rsp.evicted && rsp.evicted_id == 7'd0)
    else $error("error beat carries payload");

  a_victim_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(last_victim) |-> $past(state) == S_DECIDE)
    else $error("victim pointer moved outside decision");

endmodule

// File: sim/testbench.sv
// Self-checking bench for the buffer pool tag keeper: directed cases, then random
// traffic under four idling phases. Depends on bprr_pkg and buffer_pool_round_robin_pinning.
`timescale 1ns / 1ps

module testbench;
  import bprr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int err_count = 0;

  // own copy of the slot table, updated as each request beat is accepted
  logic [6:0]        pool_tag [POOL_SIZE];
  logic              pool_used[POOL_SIZE];
  logic              pool_pin [POOL_SIZE];
  int                pool_last_victim;

  rsp_t due_responses[$];

  buffer_pool_round_robin_pinning i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
  end

  function automatic rsp_t pool_decide(input req_t r);
    rsp_t res;
    int   s;
    int   idx;
    res = '0;
    s   = -1;
    if (r.blk_id == 7'd0 || r.command == CMD_NONE) begin
      res.status = ST_BAD_ID;
    end else begin
      for (int i = 0; i < POOL_SIZE; i++)
        if (s < 0 && pool_used[i] && pool_tag[i] == r.blk_id) s = i;
      if (r.command == CMD_UNPIN) begin
        if (s < 0) begin
          res.status = ST_NOT_RESIDENT;
        end else begin
          pool_pin[s] = 1'b0;
          res.slot    = 3'(s);
        end
      end else begin
        if (s < 0) begin
          for (int i = 0; i < POOL_SIZE; i++)
            if (s < 0 && !pool_used[i]) s = i;
          if (s < 0) begin
            // round robin from the slot after the last victim
            for (int i = 0; i < POOL_SIZE; i++) begin
              idx = (pool_last_victim + 1 + i) % POOL_SIZE;
              if (s < 0 && !pool_pin[idx]) s = idx;
            end
            if (s >= 0) begin
              res.evicted      = 1'b1;
              res.evicted_id   = pool_tag[s];
              pool_last_victim = s;
            end
          end
          if (s >= 0) begin
            pool_tag[s]      = r.blk_id;
            pool_used[s]     = 1'b1;
            pool_pin[s]      = 1'b0;
            res.fetch_needed = 1'b1;
          end
        end
        if (s < 0) begin
          res.status = ST_FULL;
          res.evicted    = 1'b0;
          res.evicted_id = '0;
        end else begin
          if (r.command == CMD_PIN) pool_pin[s] = 1'b1;
          res.slot = 3'(s);
        end
      end
    end
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [1:0] cmd, input logic [6:0] id);
    req_t r;
    r.command = cmd;
    r.blk_id = id;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req       <= '{command: 2'($urandom), blk_id: 7'($urandom)};
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    forever begin
      @(posedge clk);
      if (req_stall === 1'b0) break;
    end
    due_responses.push_back(pool_decide(r));
    @(negedge clk);
  endtask

  task automatic field_check(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (due_responses.size() == 0) begin
        $display("%0t: unexpected response beat, expected none, actual %h", $realtime, rsp);
        err_count++;
      end else begin
        want = due_responses.pop_front();
        field_check("status", 8'(want.status), 8'(rsp.status));
        field_check("slot", 8'(want.slot), 8'(rsp.slot));
        field_check("fetch_needed", 8'(want.fetch_needed), 8'(rsp.fetch_needed));
        field_check("evicted", 8'(want.evicted), 8'(rsp.evicted));
        field_check("evicted_id", 8'(want.evicted_id), 8'(rsp.evicted_id));
      end
    end
  end

  task automatic test_bad_requests();
    send_request(CMD_ACCESS, 7'd0);
    send_request(CMD_PIN, 7'd0);
    send_request(CMD_UNPIN, 7'd0);
    send_request(CMD_NONE, 7'd127);
  endtask

  // fills every slot, one of them by a pin miss, then a pin hit and an unpin of an absent id
  task automatic test_fill_and_hit();
    send_request(CMD_ACCESS, 7'd127);
    for (int i = 1; i <= 6; i++) send_request(CMD_ACCESS, 7'(i));
    send_request(CMD_PIN, 7'd9);
    send_request(CMD_PIN, 7'd2);
    send_request(CMD_UNPIN, 7'd100);
  endtask

  task automatic test_eviction();
    send_request(CMD_ACCESS, 7'd10);
  endtask

  task automatic test_all_pinned();
    send_request(CMD_PIN, 7'd10);
    send_request(CMD_PIN, 7'd1);
    for (int i = 3; i <= 6; i++) send_request(CMD_PIN, 7'(i));
    send_request(CMD_ACCESS, 7'd11);
    send_request(CMD_PIN, 7'd12);
  endtask

  // repeated pin and unpin, then a victim scan that resumes after the last one
  task automatic test_pin_state_changes();
    send_request(CMD_PIN, 7'd1);
    send_request(CMD_UNPIN, 7'd1);
    send_request(CMD_UNPIN, 7'd1);
    send_request(CMD_ACCESS, 7'd11);
  endtask

  // mostly a small id set so hits, evictions and full pools all occur
  task automatic test_random_traffic(input int count, input int id_span);
    logic [1:0] cmd;
    logic [6:0] id;
    int         roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 4)       cmd = CMD_NONE;
      else if (roll < 48) cmd = CMD_ACCESS;
      else if (roll < 76) cmd = CMD_PIN;
      else                cmd = CMD_UNPIN;
      roll = $urandom_range(99);
      if (roll < 4)       id = 7'd0;
      else if (roll < 16) id = 7'($urandom_range(127, 0));
      else                id = 7'($urandom_range(id_span, 1));
      send_request(cmd, id);
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_tag[i]  = '0;
      pool_used[i] = 1'b0;
      pool_pin[i]  = 1'b0;
    end
    pool_last_victim = POOL_SIZE - 1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_bad_requests();
    test_fill_and_hit();
    test_eviction();
    test_all_pinned();
    test_pin_state_changes();

    send_idle_pct = 0;  rsp_stall_pct = 0;
    test_random_traffic(235, 10);
    send_idle_pct = 54; rsp_stall_pct = 0;
    test_random_traffic(235, 14);
    send_idle_pct = 0;  rsp_stall_pct = 54;
    test_random_traffic(235, 9);
    send_idle_pct = 16; rsp_stall_pct = 16;
    test_random_traffic(235, 24);

    req_valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/bprr_pkg.sv
sv/bprr_scan.sv
sv/buffer_pool_round_robin_pinning.sv
sim/testbench.sv
